// File: rtl/core/phist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phist_pkg
// Shared constants, types and helpers of the pixel histogram block.
// ----------------------------------------------------------------------------
package phist_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 24;
    localparam int CHANNELS   = 3;
    localparam int BIN_BITS   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int OUT_BITS   = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [BIN_BITS-1:0]   t_bin;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic rd;
        t_bin rd_addr;
        logic bump;
        logic wipe;
        t_bin wipe_addr;
    } t_bank_cmd;

    typedef struct packed {
        logic [OUT_BITS-1:0] bin_count;
        logic                saturated;
    } t_result;

    function automatic t_bin bin_of(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'(BIN_COUNT);
        return BIN_BITS'(p >> 8);
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        if (w > 32'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return OUT_BITS'(w);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/phist_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phist_in_if
// Item channel of the pixel histogram: count, read and clear beats.
// ----------------------------------------------------------------------------
interface phist_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] chan0_value;
    logic [7:0] chan1_value;
    logic [7:0] chan2_value;
    logic [1:0] read_channel;
    logic [7:0] read_bin;

    modport source (
        output valid, op, chan0_value, chan1_value, chan2_value, read_channel, read_bin,
        input  ready
    );
    modport sink (
        input  valid, op, chan0_value, chan1_value, chan2_value, read_channel, read_bin,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/phist_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phist_out_if
// Result channel of the pixel histogram: one beat per read item.
// ----------------------------------------------------------------------------
interface phist_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] bin_count;
    logic        saturated;

    modport source (output valid, bin_count, saturated, input ready);
    modport sink (input valid, bin_count, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/core/phist_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phist_cfg_if
// Configuration write channel carrying the channel count register.
// ----------------------------------------------------------------------------
interface phist_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] channel_count;

    modport source (output valid, channel_count, input ready);
    modport sink (input valid, channel_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/phist_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phist_bank
// Bin memory of one channel with registered read, saturating increment
// write-back and forwarding of the previous write.
// ----------------------------------------------------------------------------
module phist_bank (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  phist_pkg::t_bank_cmd i_cmd,
    output phist_pkg::t_count   o_cur
);
    import phist_pkg::*;

    t_count mem [BIN_COUNT];
    t_count r_rdata;
    t_bin   r_b_addr;
    logic   r_fwd_valid;
    t_bin   r_fwd_addr;
    t_count r_fwd_data;
    t_count n_count;

    assign o_cur   = (r_fwd_valid && r_fwd_addr == r_b_addr) ? r_fwd_data : r_rdata;
    assign n_count = (o_cur != COUNT_MAX) ? o_cur + t_count'(1) : o_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata  <= mem[i_cmd.rd_addr];
            r_b_addr <= i_cmd.rd_addr;
        end
        if (i_cmd.wipe) begin
            mem[i_cmd.wipe_addr] <= '0;
        end else if (i_cmd.bump) begin
            mem[r_b_addr] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= i_cmd.bump && !i_cmd.wipe;
        end
        r_fwd_addr <= r_b_addr;
        r_fwd_data <= n_count;
    end

`ifndef SYNTHESIS
    a_no_bump_in_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wipe |-> !i_cmd.bump)
        else $error("bank increment during clearing pass");
`endif

endmodule
`default_nettype wire

// File: rtl/core/phist_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phist_outq
// Two-entry result queue that drives the result channel.
// ----------------------------------------------------------------------------
module phist_outq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  phist_pkg::t_result i_data,
    output logic [1:0]         o_count,
    phist_out_if.source        o_out
);
    import phist_pkg::*;

    t_result    r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop           = o_out.valid && o_out.ready;
    assign o_out.valid     = (r_count != 2'd0);
    assign o_out.bin_count = r_data[r_rd_ptr].bin_count;
    assign o_out.saturated = r_data[r_rd_ptr].saturated;
    assign o_count         = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2 || w_pop))
        else $error("result queue overflow");
`endif

endmodule
`default_nettype wire

// File: rtl/core/pixel_histogram_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_histogram_top
// Three-channel 8-bit image histogram with saturating bin counters.
//
//   Channel   Dir  Beat contents
//   i_in      in   op, chan0_value, chan1_value, chan2_value, read_channel, read_bin
//   o_out     out  bin_count, saturated (one beat per read item)
//   i_cfg     in   channel_count
//
// Count and read items each start with a memory read; a count item then does the
// increment and write-back in the next cycle, with the last write forwarded, and a
// read item queues its result. Input stalls while the result queue holds two beats,
// or one beat with another read result on its way. A clear item, and reset, start
// a clearing pass over all BIN_COUNT (256) bins of the three bin memories, taking
// no item. Configuration beats are taken in every cycle.
// ----------------------------------------------------------------------------
module pixel_histogram_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    phist_in_if.sink   i_in,
    phist_out_if.source o_out,
    phist_cfg_if.sink  i_cfg
);
    import phist_pkg::*;

    logic      [1:0]    r_channel_count;
    logic               r_clearing;
    t_bin               r_sweep_addr;
    logic               r_b_valid;
    logic               r_b_read;
    logic      [2:0]    r_b_en;
    logic      [1:0]    r_b_chan;
    logic               r_b_bin_ok;
    logic               w_acc;
    logic               w_rd;
    logic      [2:0]    w_en;
    logic      [1:0]    w_q_count;
    logic               w_push;
    t_result            w_result;
    t_count             w_sel;
    t_bank_cmd          w_cmd [CHANNELS];
    t_count             w_cur [CHANNELS];
    t_bin               w_pix_bin [CHANNELS];

    assign i_cfg.ready = 1'b1;

    assign i_in.ready = !r_clearing &&
        (w_q_count == 2'd0 || (w_q_count == 2'd1 && !(r_b_valid && r_b_read)));
    assign w_acc = i_in.valid && i_in.ready;
    assign w_rd  = w_acc && (i_in.op == OP_COUNT || i_in.op == OP_READ);

    always_comb begin
        case (r_channel_count)
            2'd3:    w_en = 3'b111;
            2'd2:    w_en = 3'b011;
            default: w_en = 3'b001;
        endcase
    end

    assign w_pix_bin[0] = bin_of(i_in.chan0_value);
    assign w_pix_bin[1] = bin_of(i_in.chan1_value);
    assign w_pix_bin[2] = bin_of(i_in.chan2_value);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
        always_comb begin
            w_cmd[c].rd        = w_rd;
            w_cmd[c].rd_addr   = (i_in.op == OP_READ) ? BIN_BITS'(i_in.read_bin) : w_pix_bin[c];
            w_cmd[c].bump      = r_b_valid && !r_b_read && r_b_en[c];
            w_cmd[c].wipe      = r_clearing;
            w_cmd[c].wipe_addr = r_sweep_addr;
        end

        phist_bank u_bank (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[c]),
            .o_cur   (w_cur[c])
        );
    end

    always_comb begin
        case (r_b_chan)
            2'd0:    w_sel = w_cur[0];
            2'd1:    w_sel = w_cur[1];
            2'd2:    w_sel = w_cur[2];
            default: w_sel = '0;
        endcase
    end

    assign w_push = r_b_valid && r_b_read;
    assign w_result.bin_count = (r_b_bin_ok && r_b_chan != 2'd3) ? clamp_out(w_sel) : '0;
    assign w_result.saturated = r_b_bin_ok && r_b_chan != 2'd3 && w_sel == COUNT_MAX;

    phist_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_count (w_q_count),
        .o_out   (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 2'd1;
            r_clearing      <= 1'b1;
            r_sweep_addr    <= '0;
            r_b_valid       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_channel_count <= i_cfg.channel_count;
            end
            if (r_clearing) begin
                r_sweep_addr <= r_sweep_addr + t_bin'(1);
                if (r_sweep_addr == t_bin'(BIN_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end else if (w_acc && i_in.op == OP_CLEAR) begin
                r_clearing   <= 1'b1;
                r_sweep_addr <= '0;
            end
            r_b_valid <= w_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_b_read   <= (i_in.op == OP_READ);
            r_b_en     <= w_en;
            r_b_chan   <= i_in.read_channel;
            r_b_bin_ok <= 32'(i_in.read_bin) < 32'(BIN_COUNT);
        end
    end

`ifndef SYNTHESIS
    a_clear_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.op == OP_CLEAR) |=> (r_clearing && r_sweep_addr == '0))
        else $error("clear item did not start a clearing pass");
    a_pass_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clearing && r_sweep_addr == t_bin'(BIN_COUNT - 1)) |=> !r_clearing)
        else $error("clearing pass did not end");
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_q_count != 2'd2 || o_out.ready))
        else $error("read result without queue room");
`endif

endmodule
`default_nettype wire
